// ----- hw/rtl/uvd_pkg.sv -----
// Package with the item types, status codes and byte-range constants of the varint decoder.
`default_nettype none

package uvd_pkg;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_STRAY    = 2'd1,
    STATUS_BAD_LEAD = 2'd2,
    STATUS_OVERLONG = 2'd3
  } status_t;

  localparam int unsigned VALUE_W = 21;
  localparam int unsigned COUNT_W = 3;

  // Upper bounds of the byte classes.
  localparam logic [7:0] ASCII_MAX    = 8'h7F;
  localparam logic [7:0] CONT_MAX     = 8'hBF;
  localparam logic [7:0] LEAD2_MAX    = 8'hDF;
  localparam logic [7:0] LEAD3_MAX    = 8'hEF;
  localparam logic [7:0] LEAD4_MAX    = 8'hF7;

  // Payload masks of lead and continuation bytes.
  localparam logic [7:0] CONT_MASK    = 8'h3F;
  localparam logic [7:0] LEAD2_MASK   = 8'h1F;
  localparam logic [7:0] LEAD3_MASK   = 8'h0F;
  localparam logic [7:0] LEAD4_MASK   = 8'h07;

  // Largest value that is overlong for each sequence length.
  localparam logic [VALUE_W-1:0] FLOOR2 = 21'h00007F;
  localparam logic [VALUE_W-1:0] FLOOR3 = 21'h0007FF;
  localparam logic [VALUE_W-1:0] FLOOR4 = 21'h00FFFF;

  localparam logic [COUNT_W-1:0] LEN1 = 3'd1;
  localparam logic [COUNT_W-1:0] LEN2 = 3'd2;
  localparam logic [COUNT_W-1:0] LEN3 = 3'd3;
  localparam logic [COUNT_W-1:0] LEN4 = 3'd4;

  typedef struct packed {
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    status_t            status;
    logic [COUNT_W-1:0] byte_count;
  } out_item_t;

  typedef struct packed {
    logic [1:0]         bytes_owed;
    logic [COUNT_W-1:0] seq_length;
    logic [VALUE_W-1:0] partial_value;
  } dec_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/uvd_stream_if.sv -----
// Valid/ready stream interface carrying one payload per transaction.
`default_nettype none

interface uvd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/uvd_step.sv -----
// Combinational decode of one byte against the current sequence state.
`default_nettype none

module uvd_step (
  input  uvd_pkg::dec_state_t state,
  input  logic [7:0]          in_byte,
  output uvd_pkg::dec_state_t state_next,
  output logic                emit,
  output uvd_pkg::out_item_t  item
);
  import uvd_pkg::*;

  logic [VALUE_W-1:0] shifted;
  logic [VALUE_W-1:0] floor_val;

  assign shifted = {state.partial_value[VALUE_W-7:0], in_byte[5:0] & CONT_MASK[5:0]};

  always_comb begin
    priority if (state.seq_length == LEN2) begin
      floor_val = FLOOR2;
    end else if (state.seq_length == LEN3) begin
      floor_val = FLOOR3;
    end else begin
      floor_val = FLOOR4;
    end
  end

  always_comb begin
    state_next      = state;
    emit            = 1'b0;
    item.value      = '0;
    item.status     = STATUS_OK;
    item.byte_count = LEN1;
    if (state.bytes_owed == 2'd0) begin
      priority if (in_byte <= ASCII_MAX) begin
        emit       = 1'b1;
        item.value = VALUE_W'(in_byte);
      end else if (in_byte <= CONT_MAX) begin
        emit        = 1'b1;
        item.status = STATUS_STRAY;
      end else if (in_byte <= LEAD2_MAX) begin
        state_next.bytes_owed    = 2'd1;
        state_next.seq_length    = LEN2;
        state_next.partial_value = VALUE_W'(in_byte & LEAD2_MASK);
      end else if (in_byte <= LEAD3_MAX) begin
        state_next.bytes_owed    = 2'd2;
        state_next.seq_length    = LEN3;
        state_next.partial_value = VALUE_W'(in_byte & LEAD3_MASK);
      end else if (in_byte <= LEAD4_MAX) begin
        state_next.bytes_owed    = 2'd3;
        state_next.seq_length    = LEN4;
        state_next.partial_value = VALUE_W'(in_byte & LEAD4_MASK);
      end else begin
        emit        = 1'b1;
        item.status = STATUS_BAD_LEAD;
      end
    end else if (state.bytes_owed == 2'd1) begin
      // Last continuation byte: close the sequence and return to idle.
      state_next      = '0;
      emit            = 1'b1;
      item.byte_count = state.seq_length;
      if (shifted > floor_val) begin
        item.value = shifted;
      end else begin
        item.status = STATUS_OVERLONG;
      end
    end else begin
      state_next.bytes_owed    = state.bytes_owed - 2'd1;
      state_next.partial_value = shifted;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/utf8_style_varint_decoder.sv -----
// Top level of the UTF-8 style variable-length integer decoder.
// Throughput: one byte per cycle while each result is taken as it appears; a result left waiting
// holds the input off until it is taken, since there is one result register.
// Latency: a result is valid in the cycle after the transaction of its last byte.
// Reset (synchronous, active high) returns the decoder to idle and drops any
// pending result.
`default_nettype none

module utf8_style_varint_decoder (
  input  logic         clk,
  input  logic         rst,
  uvd_stream_if.sink   byte_stream,
  uvd_stream_if.source result
);
  import uvd_pkg::*;

  dec_state_t state;
  dec_state_t state_next;
  logic       step_emit;
  out_item_t  step_item;
  logic       out_valid;
  out_item_t  out_item;
  logic       accept;

  // The decoder takes a byte whenever the result register is empty or is being
  // emptied in the same cycle, so a full register never blocks a free output.
  assign byte_stream.ready = !out_valid || result.ready;
  assign accept            = byte_stream.valid && byte_stream.ready;

  uvd_step u_step (
    .state      (state),
    .in_byte    (byte_stream.data.in_byte),
    .state_next (state_next),
    .emit       (step_emit),
    .item       (step_item)
  );

  // Sequence state: owed byte count, sequence length and the partial value.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // Result register. A byte that does not close a sequence leaves it empty;
  // the previous result has then been taken, since accepting needs ready.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= step_emit;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && step_emit) begin
      out_item <= step_item;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_item;

endmodule

`default_nettype wire

// ----- hw/rtl/uvd_checker.sv -----
// Port-level checks of the varint decoder and their binding to the top level.
`default_nettype none

module uvd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [uvd_pkg::VALUE_W-1:0]   value,
  input logic [1:0]                    status,
  input logic [uvd_pkg::COUNT_W-1:0]   byte_count
);
  import uvd_pkg::*;

  // A result that is not taken stays on the port unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({value, status, byte_count}))
    else $error("result changed while stalled");

  // Every error result carries a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STATUS_OK |-> value == '0)
    else $error("error result with non-zero value");

  // Stray continuation and bad lead bytes are single-byte results.
  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_STRAY || status == STATUS_BAD_LEAD) |-> byte_count == LEN1)
    else $error("single-byte error with wrong byte count");

  // Overlong forms need two bytes at least, and no sequence exceeds four.
  a_overlong: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_OVERLONG |->
      (byte_count == LEN2 || byte_count == LEN3 || byte_count == LEN4))
    else $error("overlong result with bad byte count");

  // A one-byte good result never exceeds seven bits.
  a_ascii: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_OK && byte_count == LEN1 |-> value <= VALUE_W'(ASCII_MAX))
    else $error("one-byte result out of range");

endmodule

bind utf8_style_varint_decoder uvd_checker u_uvd_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .value      (result.data.value),
  .status     (result.data.status),
  .byte_count (result.data.byte_count)
);

`default_nettype wire

// ----- dv/utf8_style_varint_decoder_tb.sv -----
// Self-checking testbench for the UTF-8 style varint decoder, with its result scoreboard.
`default_nettype none

module utf8_style_varint_decoder_tb;
  import uvd_pkg::*;

  // Roughly how many bytes the whole run offers to the decoder.
  localparam int unsigned STREAM_BYTES = 1150;
  // The final stretch of the run is offered with no idling on either side.
  localparam int unsigned CALM_BYTES = 150;
  // Cycles without any transaction after which the run is declared hung.
  localparam int unsigned STALL_LIMIT = 1000;
  // Idle edges after the drain; results appear in the cycle after their last byte.
  localparam int unsigned SETTLE_CYCLES = 4;

  localparam logic [VALUE_W-1:0] MAX2 = 21'h0007FF;
  localparam logic [VALUE_W-1:0] MAX3 = 21'h00FFFF;
  localparam logic [VALUE_W-1:0] MAX4 = 21'h1FFFFF;

  // Tracks the decoder state on its own and holds the results that are still owed.
  class varint_scoreboard;
    logic [1:0]         owed = '0;
    logic [COUNT_W-1:0] seq_len = '0;
    logic [VALUE_W-1:0] partial = '0;
    out_item_t          awaited_results[$];
    int unsigned        mismatches = 0;

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    function void await_result(logic [VALUE_W-1:0] v, status_t s, logic [COUNT_W-1:0] n);
      out_item_t r;
      r.value = v;
      r.status = s;
      r.byte_count = n;
      awaited_results.push_back(r);
    endfunction

    // Called for every byte the decoder accepts.
    function void absorb_byte(logic [7:0] b);
      logic [VALUE_W-1:0] floor_v;
      if (owed == 2'd0) begin
        if (b <= ASCII_MAX) begin
          await_result({13'd0, b}, STATUS_OK, LEN1);
        end else if (b <= CONT_MAX) begin
          await_result('0, STATUS_STRAY, LEN1);
        end else if (b <= LEAD2_MAX) begin
          owed = 2'd1;
          seq_len = LEN2;
          partial = {13'd0, b & LEAD2_MASK};
        end else if (b <= LEAD3_MAX) begin
          owed = 2'd2;
          seq_len = LEN3;
          partial = {13'd0, b & LEAD3_MASK};
        end else if (b <= LEAD4_MAX) begin
          owed = 2'd3;
          seq_len = LEN4;
          partial = {13'd0, b & LEAD4_MASK};
        end else begin
          await_result('0, STATUS_BAD_LEAD, LEN1);
        end
      end else begin
        // The top two bits of a continuation byte are dropped, never checked.
        partial = {partial[VALUE_W-7:0], b[5:0]};
        owed = owed - 2'd1;
        if (owed == 2'd0) begin
          if (seq_len == LEN2) floor_v = FLOOR2;
          else if (seq_len == LEN3) floor_v = FLOOR3;
          else floor_v = FLOOR4;
          if (partial > floor_v) await_result(partial, STATUS_OK, seq_len);
          else await_result('0, STATUS_OVERLONG, seq_len);
          seq_len = '0;
          partial = '0;
        end
      end
    endfunction

    task check_result(out_item_t got);
      out_item_t want;
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result value %h status %0d count %0d",
                                  got.value, got.status, got.byte_count));
      end else begin
        want = awaited_results.pop_front();
        if (got.value !== want.value)
          report_mismatch($sformatf("value %h, wanted %h", got.value, want.value));
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d, wanted %0d", got.status, want.status));
        if (got.byte_count !== want.byte_count)
          report_mismatch($sformatf("byte_count %0d, wanted %0d",
                                    got.byte_count, want.byte_count));
      end
    endtask

    task report_leftovers();
      while (awaited_results.size() != 0) begin
        report_mismatch($sformatf("result never arrived: value %h status %0d",
                                  awaited_results[0].value, awaited_results[0].status));
        void'(awaited_results.pop_front());
      end
    endtask

    function int unsigned outstanding();
      return awaited_results.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  // The calm flag switches off idling on both sides for the closing stretch.
  logic        calm = 1'b0;
  int unsigned bytes_sent = 0;
  int unsigned quiet_cycles = 0;

  varint_scoreboard tracker = new();

  uvd_stream_if #(.payload_t(in_item_t))  byte_if ();
  uvd_stream_if #(.payload_t(out_item_t)) res_if ();

  utf8_style_varint_decoder dut (
    .clk         (clk),
    .rst         (rst),
    .byte_stream (byte_if),
    .result      (res_if)
  );

  always #10 clk = ~clk;

  // Every input starts at a known value before the first edge.
  initial begin
    byte_if.valid = 1'b0;
    byte_if.data = '0;
    res_if.ready = 1'b0;
  end

  // Monitor: all handshake signals are read at the rising edge, before any
  // nonblocking update of that edge lands, so the view is free of races.
  always @(posedge clk) begin
    if (!rst) begin
      if (byte_if.valid && byte_if.ready) tracker.absorb_byte(byte_if.data.in_byte);
      if (res_if.valid && res_if.ready) tracker.check_result(res_if.data);
    end
  end

  // Watchdog: a run in which nothing moves for too long is hung.
  always @(posedge clk) begin
    if (rst || (byte_if.valid && byte_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Result side: ready is held in random bursts, stalls mixed at random
  // with open stretches; once the calm flag is up it stays high.
  initial begin
    int unsigned span;
    bit          stall;
    forever begin
      if (calm || rst) begin
        res_if.ready <= 1'b1;
        @(posedge clk);
      end else begin
        stall = ($urandom_range(0, 2) == 0);
        span = stall ? $urandom_range(1, 12) : $urandom_range(1, 30);
        res_if.ready <= !stall;
        repeat (span) @(posedge clk);
      end
    end
  end

  // Offers one byte and returns at the edge of its transaction. Valid is only
  // ever raised here, so a back-to-back byte never sees valid dropped and
  // raised within the same time step.
  task automatic send_byte(logic [7:0] b);
    int unsigned gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      byte_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_if.valid <= 1'b1;
    byte_if.data.in_byte <= b;
    do @(posedge clk); while (!byte_if.ready);
    bytes_sent++;
  endtask

  // Holds the byte stream until every result owed so far has been taken. The
  // wait checks only after an edge, so that the monitor has seen the last byte.
  task automatic drain_results();
    byte_if.valid <= 1'b0;
    do @(posedge clk); while (tracker.outstanding() != 0);
  endtask

  // Writes a value in the canonical layout of the given length; the value is
  // truncated to what that length can carry, so small ones come out overlong.
  task automatic send_encoded(int unsigned len, logic [VALUE_W-1:0] v);
    case (len)
      1: send_byte({1'b0, v[6:0]});
      2: begin
        send_byte({3'b110, v[10:6]});
        send_byte({2'b10, v[5:0]});
      end
      3: begin
        send_byte({4'b1110, v[15:12]});
        send_byte({2'b10, v[11:6]});
        send_byte({2'b10, v[5:0]});
      end
      default: begin
        send_byte({5'b11110, v[20:18]});
        send_byte({2'b10, v[17:12]});
        send_byte({2'b10, v[11:6]});
        send_byte({2'b10, v[5:0]});
      end
    endcase
  endtask

  // Picks a value for a sequence of the given length: mostly anywhere in range,
  // but often at the overlong boundary, at the very top or in the overlong range.
  function automatic logic [VALUE_W-1:0] pick_value(int unsigned len);
    logic [VALUE_W-1:0] floor_v;
    logic [VALUE_W-1:0] top;
    int unsigned        mode;
    if (len == 2) begin
      floor_v = FLOOR2;
      top = MAX2;
    end else if (len == 3) begin
      floor_v = FLOOR3;
      top = MAX3;
    end else begin
      floor_v = FLOOR4;
      top = MAX4;
    end
    mode = $urandom_range(0, 9);
    if (len == 1) return VALUE_W'($urandom_range(0, 127));
    if (mode < 6) return VALUE_W'($urandom_range(0, top));
    if (mode < 8) return floor_v - VALUE_W'(3) + VALUE_W'($urandom_range(0, 6));
    if (mode == 8) return top;
    return VALUE_W'($urandom_range(0, floor_v));
  endfunction

  // A lead byte followed by continuation bytes of arbitrary content, so that
  // lead-like and ASCII-like bytes land where continuation bytes are owed.
  task automatic send_broken_sequence();
    logic [7:0] lead;
    int unsigned follow;
    lead = 8'($urandom_range(CONT_MAX + 1, LEAD4_MAX));
    if (lead <= LEAD2_MAX) follow = 1;
    else if (lead <= LEAD3_MAX) follow = 2;
    else follow = 3;
    send_byte(lead);
    repeat (follow) send_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin
    logic [7:0]  directed[$];
    int unsigned pick;
    bit          paused_midway;

    paused_midway = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed bytes: single-byte extremes, stray continuation bytes and bad
    // leads, the smallest two-byte value and its overlong neighbour, an
    // overlong three-byte form whose last byte has lead-like top bits, a
    // surrogate, and the largest four-byte value with its overlong twin.
    directed = '{8'h00, 8'h7F, 8'h80, 8'hBF, 8'hF8, 8'hFF,
                 8'hC2, 8'h80, 8'hC1, 8'hBF,
                 8'hE0, 8'h9F, 8'hFF,
                 8'hED, 8'hA0, 8'h80,
                 8'hF7, 8'hBF, 8'hBF, 8'hBF,
                 8'hF0, 8'h8F, 8'hBF, 8'hBF};
    foreach (directed[i]) send_byte(directed[i]);

    // Let the directed results all come home before the random traffic.
    drain_results();

    // Random traffic: mostly well-formed sequences with random content, the
    // rest loose noise bytes and sequences with arbitrary continuation bytes.
    while (bytes_sent < STREAM_BYTES) begin
      if (!paused_midway && bytes_sent >= STREAM_BYTES / 2) begin
        drain_results();
        paused_midway = 1'b1;
      end
      if (bytes_sent >= STREAM_BYTES - CALM_BYTES) calm = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 27) begin
        send_broken_sequence();
      end else begin
        pick = $urandom_range(1, 4);
        send_encoded(pick, pick_value(pick));
      end
    end

    // A truncated sequence at the very end would leave the decoder waiting,
    // so finish with random bytes until whatever is still open is closed.
    while (tracker.owed != 2'd0) send_byte(8'($urandom_range(0, 255)));

    byte_if.valid <= 1'b0;
    do @(posedge clk); while (tracker.outstanding() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    tracker.report_leftovers();
    if (tracker.mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire
